/* hw/rtl/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the cartridge bank mapper modules.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // Address geometry of the mapped ROM spaces
    localparam int PRG_OFS_W = 13;
    localparam int CHR_OFS_W = 10;
    localparam int MADDR_W   = 21;

    typedef logic [MADDR_W-1:0]   t_maddr;
    typedef logic [PRG_OFS_W-1:0] t_ofs;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_REG_WR    = 2'd0,
        OP_TICK      = 2'd1,
        OP_CPU_FETCH = 2'd2,
        OP_PPU_FETCH = 2'd3
    } t_op;

    // Register groups, decoded from CPU address bits 6..4
    localparam logic [2:0] GRP_PRG         = 3'd0;
    localparam logic [2:0] GRP_CHR_LO      = 3'd1;
    localparam logic [2:0] GRP_CHR_HI      = 3'd2;
    localparam logic [2:0] GRP_IRQ_RESTART = 3'd3;
    localparam logic [2:0] GRP_IRQ_ACK     = 3'd4;
    localparam logic [2:0] GRP_NT          = 3'd5;

    // PRG slot whose bank is hardwired to all ones
    localparam logic [1:0] PRG_FIXED_SLOT = 2'd3;

    // PPU address bits 13..8 of the palette page
    localparam logic [5:0] PALETTE_PAGE = 6'h3F;

    // Counter bits that raise the interrupt, per board variant
    localparam int IRQ_BIT_V0 = 10;
    localparam int IRQ_BIT_V1 = 12;

    // Board variant codes
    localparam logic VARIANT_REG5 = 1'b0;
    localparam logic VARIANT_CHR7 = 1'b1;

    // Short queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified command kinds
    typedef enum logic [3:0] {
        K_NOP,
        K_PRG_WR,
        K_CHR_LO_WR,
        K_CHR_HI_WR,
        K_IRQ_RESTART,
        K_IRQ_ACK,
        K_NT_WR,
        K_TICK,
        K_CPU_FETCH,
        K_PPU_CHR,
        K_PPU_NT
    } t_kind;

    typedef struct packed {
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  cycles;
    } t_in_item;

    typedef struct packed {
        t_maddr mapped_addr;
        logic   mapped_valid;
        logic   is_nametable;
        logic   ciram_page;
        logic   irq;
    } t_out_item;

    // Command handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  idx;
        logic [7:0]  arg;
        t_ofs        offset;
    } t_cmd;

    // Front-to-queue push group
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    // Queue-to-back read group
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

/* hw/rtl/cbm_if.sv */
// ----------------------------------------------------------------------------
// cbm_if
// Valid/ready channels of the cartridge bank mapper: items, results, config.
// ----------------------------------------------------------------------------
interface cbm_in_if;
    logic              valid;
    logic              ready;
    cbm_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface cbm_out_if;
    logic               valid;
    logic               ready;
    cbm_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface cbm_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/cartridge_bank_mapper_irq.sv */
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq
// Cartridge bank mapper with a cycle-counting interrupt.
// ----------------------------------------------------------------------------
// Usage: items enter on i_in (register write, cycle tick, CPU fetch or PPU
// fetch); every item yields exactly one result word on o_out, in order,
// carrying the translated ROM address, the nametable page and the IRQ level
// after the item. The user must write the board variant on i_cfg only while
// the block is idle; the block does not enforce this. i_cfg is always ready.
// Path: the front classifies each accepted word into a two-entry queue; the
// back executes one command per cycle, while o_out takes its results, into
// the output register, and words queued ahead of a word delay it.
// Throughput: one item per cycle while o_out is ready, set by the single
// back-end execute stage that owns the bank registers and counter.
// Stalls: when o_out is not ready the back holds its result and the queue
// fills; i_in.ready drops once both queue entries are held.
// Reset (i_rst_n low, synchronous): banks, nametable pages, counter, IRQ
// state, queue and variant are cleared; no output word is valid.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq #(
    parameter int PRG_BANK_BITS = 8,
    parameter int CHR_BANK_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbm_in_if.sink    i_in,
    cbm_cfg_if.sink   i_cfg,
    cbm_out_if.source o_out
);

    cbm_pkg::t_push w_push;
    cbm_pkg::t_head w_head;
    logic           w_full;
    logic           w_pop;

    cbm_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push)
    );

    cbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    cbm_back #(
        .PRG_BANK_BITS (PRG_BANK_BITS),
        .CHR_BANK_BITS (CHR_BANK_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

/* hw/rtl/cbm_front.sv */
// ----------------------------------------------------------------------------
// cbm_front
// Accepts items and classifies them into mapper commands for the queue.
// ----------------------------------------------------------------------------
module cbm_front (
    cbm_in_if.sink          i_in,
    input  logic            i_full,
    output cbm_pkg::t_push  o_push
);

    logic [15:0]   w_addr;
    logic [1:0]    w_slot;
    logic [13:0]   w_ppu;
    cbm_pkg::t_cmd w_cmd;

    assign w_addr = i_in.item.addr;
    assign w_slot = w_addr[1:0];
    assign w_ppu  = w_addr[13:0];

    // Take an item whenever the queue has room
    assign i_in.ready   = !i_full;
    assign o_push.valid = i_in.valid && !i_full;
    assign o_push.cmd   = w_cmd;

    // Classify the item
    always_comb begin
        w_cmd.kind   = cbm_pkg::K_NOP;
        w_cmd.idx    = 3'd0;
        w_cmd.arg    = i_in.item.data;
        w_cmd.offset = w_addr[cbm_pkg::PRG_OFS_W-1:0];
        case (i_in.item.op)
            cbm_pkg::OP_REG_WR: begin
                w_cmd.idx = {1'b0, w_slot};
                if (w_addr[15]) begin
                    case (w_addr[6:4])
                        cbm_pkg::GRP_PRG: begin
                            if (w_slot != cbm_pkg::PRG_FIXED_SLOT) begin
                                w_cmd.kind = cbm_pkg::K_PRG_WR;
                            end
                        end
                        cbm_pkg::GRP_CHR_LO:      w_cmd.kind = cbm_pkg::K_CHR_LO_WR;
                        cbm_pkg::GRP_CHR_HI: begin
                            w_cmd.kind = cbm_pkg::K_CHR_HI_WR;
                            w_cmd.idx  = {1'b1, w_slot};
                        end
                        cbm_pkg::GRP_IRQ_RESTART: w_cmd.kind = cbm_pkg::K_IRQ_RESTART;
                        cbm_pkg::GRP_IRQ_ACK:     w_cmd.kind = cbm_pkg::K_IRQ_ACK;
                        cbm_pkg::GRP_NT:          w_cmd.kind = cbm_pkg::K_NT_WR;
                        default:                  w_cmd.kind = cbm_pkg::K_NOP;
                    endcase
                end
            end
            cbm_pkg::OP_TICK: begin
                w_cmd.kind = cbm_pkg::K_TICK;
                w_cmd.arg  = i_in.item.cycles;
            end
            cbm_pkg::OP_CPU_FETCH: begin
                w_cmd.idx = {1'b0, w_addr[14:13]};
                if (w_addr[15]) begin
                    w_cmd.kind = cbm_pkg::K_CPU_FETCH;
                end
            end
            cbm_pkg::OP_PPU_FETCH: begin
                w_cmd.offset = {3'd0, w_ppu[cbm_pkg::CHR_OFS_W-1:0]};
                if (!w_ppu[13]) begin
                    w_cmd.kind = cbm_pkg::K_PPU_CHR;
                    w_cmd.idx  = w_ppu[12:10];
                end else if (w_ppu[13:8] != cbm_pkg::PALETTE_PAGE) begin
                    w_cmd.kind = cbm_pkg::K_PPU_NT;
                    w_cmd.idx  = {1'b0, w_ppu[11:10]};
                end
            end
            default: w_cmd.kind = cbm_pkg::K_NOP;
        endcase
    end

endmodule

/* hw/rtl/cbm_queue.sv */
// ----------------------------------------------------------------------------
// cbm_queue
// Short command FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module cbm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbm_pkg::t_push  i_push,
    output logic            o_full,
    output cbm_pkg::t_head  o_head,
    input  logic            i_pop
);

    cbm_pkg::t_cmd                   r_mem [cbm_pkg::QUEUE_DEPTH];
    logic [cbm_pkg::QPTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [cbm_pkg::QPTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [cbm_pkg::QCNT_W-1:0]      r_count, n_count;
    logic                            w_push, w_pop;

    assign o_full      = (r_count == cbm_pkg::QCNT_W'(cbm_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    assign w_push = i_push.valid && !o_full;
    assign w_pop  = i_pop && o_head.valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == cbm_pkg::QPTR_W'(cbm_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == cbm_pkg::QPTR_W'(cbm_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

endmodule

/* hw/rtl/cbm_back.sv */
// ----------------------------------------------------------------------------
// cbm_back
// Executes mapper commands: bank registers, IRQ counter, address translation.
// ----------------------------------------------------------------------------
module cbm_back #(
    parameter int PRG_BANK_BITS = 8,
    parameter int CHR_BANK_BITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbm_pkg::t_head  i_head,
    output logic            o_pop,
    cbm_cfg_if.sink         i_cfg,
    cbm_out_if.source       o_out
);

    logic [PRG_BANK_BITS-1:0] r_prg [3];
    logic [PRG_BANK_BITS-1:0] n_prg [3];
    logic [CHR_BANK_BITS-1:0] r_chr [8];
    logic [CHR_BANK_BITS-1:0] n_chr [8];
    logic [3:0]               r_nt, n_nt;
    logic                     r_irq_en, n_irq_en;
    logic [15:0]              r_count, n_count;
    logic                     r_irq, n_irq;
    logic                     r_variant;
    logic                     r_out_valid;
    cbm_pkg::t_out_item       r_out, n_out;

    logic                     w_fire;
    logic [15:0]              w_sum;
    logic                     w_hit;
    logic [PRG_BANK_BITS-1:0] w_prg_bank;
    cbm_pkg::t_cmd            w_cmd;

    assign w_cmd  = i_head.cmd;
    assign w_fire = i_head.valid && (!r_out_valid || o_out.ready);
    assign o_pop  = w_fire;

    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    // Counter sum and variant's interrupt bit
    assign w_sum = r_count + {8'd0, w_cmd.arg};
    assign w_hit = (r_variant == cbm_pkg::VARIANT_CHR7) ? w_sum[cbm_pkg::IRQ_BIT_V1] :
                                                          w_sum[cbm_pkg::IRQ_BIT_V0];

    // PRG bank for the fetched slot, last slot fixed to all ones
    always_comb begin
        case (w_cmd.idx[1:0])
            2'd0:    w_prg_bank = r_prg[0];
            2'd1:    w_prg_bank = r_prg[1];
            2'd2:    w_prg_bank = r_prg[2];
            default: w_prg_bank = '1;
        endcase
    end

    // Apply the command to the mapper state and form the result
    always_comb begin
        n_prg    = r_prg;
        n_chr    = r_chr;
        n_nt     = r_nt;
        n_irq_en = r_irq_en;
        n_count  = r_count;
        n_irq    = r_irq;
        n_out    = '0;
        case (w_cmd.kind)
            cbm_pkg::K_PRG_WR: begin
                n_prg[w_cmd.idx[1:0]] = w_cmd.arg[PRG_BANK_BITS-1:0];
            end
            cbm_pkg::K_CHR_LO_WR: begin
                n_chr[w_cmd.idx] = w_cmd.arg[CHR_BANK_BITS-1:0];
                if (r_variant == cbm_pkg::VARIANT_CHR7) begin
                    n_nt[w_cmd.idx[1:0]] = w_cmd.arg[7];
                end
            end
            cbm_pkg::K_CHR_HI_WR: begin
                n_chr[w_cmd.idx] = w_cmd.arg[CHR_BANK_BITS-1:0];
            end
            cbm_pkg::K_IRQ_RESTART: begin
                n_count  = '0;
                n_irq_en = 1'b1;
            end
            cbm_pkg::K_IRQ_ACK: begin
                n_irq_en = 1'b0;
                n_irq    = 1'b0;
            end
            cbm_pkg::K_NT_WR: begin
                if (r_variant == cbm_pkg::VARIANT_REG5) begin
                    n_nt[w_cmd.idx[1:0]] = w_cmd.arg[0];
                end
            end
            cbm_pkg::K_TICK: begin
                n_count = w_sum;
                if (r_irq_en && w_hit) begin
                    n_irq = 1'b1;
                end
            end
            cbm_pkg::K_CPU_FETCH: begin
                n_out.mapped_addr  = cbm_pkg::t_maddr'({w_prg_bank, w_cmd.offset});
                n_out.mapped_valid = 1'b1;
            end
            cbm_pkg::K_PPU_CHR: begin
                n_out.mapped_addr  = cbm_pkg::t_maddr'({r_chr[w_cmd.idx],
                                     w_cmd.offset[cbm_pkg::CHR_OFS_W-1:0]});
                n_out.mapped_valid = 1'b1;
            end
            cbm_pkg::K_PPU_NT: begin
                n_out.is_nametable = 1'b1;
                n_out.ciram_page   = r_nt[w_cmd.idx[1:0]];
            end
            default: n_out = '0;
        endcase
        n_out.irq = n_irq;
    end

    // Hold mapper state, updated only when a command is executed; the variant loads on each config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg       <= '{default: '0};
            r_chr       <= '{default: '0};
            r_nt        <= '0;
            r_irq_en    <= 1'b0;
            r_count     <= '0;
            r_irq       <= 1'b0;
            r_variant   <= cbm_pkg::VARIANT_REG5;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_variant <= i_cfg.data;
            end
            if (w_fire) begin
                r_prg    <= n_prg;
                r_chr    <= n_chr;
                r_nt     <= n_nt;
                r_irq_en <= n_irq_en;
                r_count  <= n_count;
                r_irq    <= n_irq;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

endmodule

/* tb/tb_cartridge_bank_mapper_irq.sv */
// ----------------------------------------------------------------------------
// tb_cartridge_bank_mapper_irq
// Self-checking testbench for the cartridge bank mapper with cycle IRQ.
// A scoreboard class tracks bank, nametable and counter state in step with
// every accepted item and checks each result word in order. Stimulus runs a
// short directed set per board variant, then random items mixed with IRQ
// sequences (restart, runs of ticks, acknowledge). Both sides idle at random,
// and once the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_irq;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PRG_BANK_BITS = 8;
    localparam int          CHR_BANK_BITS = 8;
    localparam int          GAP_MAX       = 10;
    localparam int          LONG_HOLD     = 300;
    localparam int          DRAIN_PAUSE   = 4;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the mapper state and holds the expected words
    // ------------------------------------------------------------------------
    class mapper_scoreboard;
        logic                 variant;
        logic [7:0]           prg_bank [3];
        logic [7:0]           chr_bank [8];
        logic                 nt_page [4];
        logic                 irq_en;
        logic [15:0]          cyc_cnt;
        logic                 irq_pend;
        cbm_pkg::t_out_item   expected_words [$];
        int                   errors;
        int                   words_checked;
        int                   irq_words;
        int                   cfg_writes;
        int                   op_seen [4];

        function new();
            variant  = cbm_pkg::VARIANT_REG5;
            irq_en   = 1'b0;
            cyc_cnt  = '0;
            irq_pend = 1'b0;
            foreach (prg_bank[i]) prg_bank[i] = '0;
            foreach (chr_bank[i]) chr_bank[i] = '0;
            foreach (nt_page[i]) nt_page[i] = 1'b0;
            errors        = 0;
            words_checked = 0;
            irq_words     = 0;
            cfg_writes    = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        function void set_variant(logic v);
            variant = v;
            cfg_writes++;
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction

        // Apply one accepted item to the mirrored state, queue its result
        function void note_item(cbm_pkg::t_in_item it);
            cbm_pkg::t_out_item res;
            logic [2:0]         grp;
            logic [1:0]         slot;
            logic [13:0]        pa;
            logic [7:0]         bank;
            int                 irq_idx;
            res = '0;
            op_seen[it.op]++;
            case (it.op)
                cbm_pkg::OP_REG_WR: begin
                    grp  = it.addr[6:4];
                    slot = it.addr[1:0];
                    if (it.addr[15]) begin
                        case (grp)
                            cbm_pkg::GRP_PRG: begin
                                if (slot != cbm_pkg::PRG_FIXED_SLOT) prg_bank[slot] = it.data;
                            end
                            cbm_pkg::GRP_CHR_LO: begin
                                chr_bank[{1'b0, slot}] = it.data;
                                if (variant == cbm_pkg::VARIANT_CHR7) nt_page[slot] = it.data[7];
                            end
                            cbm_pkg::GRP_CHR_HI: chr_bank[{1'b1, slot}] = it.data;
                            cbm_pkg::GRP_IRQ_RESTART: begin
                                cyc_cnt = '0;
                                irq_en  = 1'b1;
                            end
                            cbm_pkg::GRP_IRQ_ACK: begin
                                irq_en   = 1'b0;
                                irq_pend = 1'b0;
                            end
                            cbm_pkg::GRP_NT: begin
                                if (variant == cbm_pkg::VARIANT_REG5) nt_page[slot] = it.data[0];
                            end
                            default: ;
                        endcase
                    end
                end
                cbm_pkg::OP_TICK: begin
                    irq_idx = (variant == cbm_pkg::VARIANT_CHR7) ? cbm_pkg::IRQ_BIT_V1 :
                                                                   cbm_pkg::IRQ_BIT_V0;
                    cyc_cnt = cyc_cnt + 16'(it.cycles);
                    if (irq_en && cyc_cnt[irq_idx]) irq_pend = 1'b1;
                end
                cbm_pkg::OP_CPU_FETCH: begin
                    if (it.addr[15]) begin
                        slot = it.addr[14:13];
                        bank = (slot == cbm_pkg::PRG_FIXED_SLOT) ? 8'hFF : prg_bank[slot];
                        bank = bank & 8'((1 << PRG_BANK_BITS) - 1);
                        res.mapped_addr  = (cbm_pkg::t_maddr'(bank) << cbm_pkg::PRG_OFS_W)
                                         | cbm_pkg::t_maddr'(it.addr[cbm_pkg::PRG_OFS_W-1:0]);
                        res.mapped_valid = 1'b1;
                    end
                end
                default: begin
                    // PPU bus decodes only 14 address bits
                    pa = it.addr[13:0];
                    if (!pa[13]) begin
                        bank = chr_bank[pa[12:10]] & 8'((1 << CHR_BANK_BITS) - 1);
                        res.mapped_addr  = (cbm_pkg::t_maddr'(bank) << cbm_pkg::CHR_OFS_W)
                                         | cbm_pkg::t_maddr'(pa[cbm_pkg::CHR_OFS_W-1:0]);
                        res.mapped_valid = 1'b1;
                    end else if (pa[13:8] != cbm_pkg::PALETTE_PAGE) begin
                        res.is_nametable = 1'b1;
                        res.ciram_page   = nt_page[pa[11:10]];
                    end
                end
            endcase
            res.irq = irq_pend;
            expected_words.push_back(res);
        endfunction

        function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, got %0h",
                         $time, name, exp_v, got_v);
            end
        endfunction

        // Compare one result word against the oldest expectation
        function void check_word(cbm_pkg::t_out_item got);
            cbm_pkg::t_out_item exp_w;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result word, expected none, got %h",
                         $time, got);
                return;
            end
            exp_w = expected_words.pop_front();
            words_checked++;
            if (got.irq) irq_words++;
            cmp_field("mapped_addr", 32'(exp_w.mapped_addr), 32'(got.mapped_addr));
            cmp_field("mapped_valid", 32'(exp_w.mapped_valid), 32'(got.mapped_valid));
            cmp_field("is_nametable", 32'(exp_w.is_nametable), 32'(got.is_nametable));
            cmp_field("ciram_page", 32'(exp_w.ciram_page), 32'(got.ciram_page));
            cmp_field("irq", 32'(exp_w.irq), 32'(got.irq));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cbm_in_if  in_if ();
    cbm_cfg_if cfg_if ();
    cbm_out_if out_if ();

    cartridge_bank_mapper_irq #(
        .PRG_BANK_BITS(PRG_BANK_BITS),
        .CHR_BANK_BITS(CHR_BANK_BITS)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    mapper_scoreboard board = new();
    bit               gaps_on  = 1'b1;
    bit               hold_req = 1'b0;
    int unsigned      cycle_no = 0;

    // ------------------------------------------------------------------------
    // Watch all three handshakes at the clock edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready) board.set_variant(cfg_if.data);
            if (in_if.valid && in_if.ready) board.note_item(in_if.item);
            if (out_if.valid && out_if.ready) board.check_word(out_if.item);
        end
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d words still expected", $time, board.outstanding());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stall per word, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        forever begin
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            stall = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
            while (!out_if.valid) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    function automatic cbm_pkg::t_in_item mk_item(cbm_pkg::t_op op, logic [15:0] addr,
                                                  logic [7:0] data, logic [7:0] cycles);
        cbm_pkg::t_in_item it;
        it.op     = op;
        it.addr   = addr;
        it.data   = data;
        it.cycles = cycles;
        return it;
    endfunction

    // Offer one word; return at the edge where it is taken
    task automatic send_item(cbm_pkg::t_in_item it);
        int gap;
        gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.item  <= it;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    task automatic send_batch(ref cbm_pkg::t_in_item batch [$]);
        foreach (batch[i]) send_item(batch[i]);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic cfg_write(logic v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Register write into a chosen group, random high bits and slot
    function automatic cbm_pkg::t_in_item group_write(logic [2:0] grp);
        cbm_pkg::t_in_item it;
        it       = mk_item(cbm_pkg::OP_REG_WR, 16'($urandom), 8'($urandom), 8'($urandom));
        it.addr[15]  = 1'b1;
        it.addr[6:4] = grp;
        return it;
    endfunction

    function automatic cbm_pkg::t_in_item rand_item();
        cbm_pkg::t_in_item it;
        logic [2:0]        grp;
        int                pick;
        pick = $urandom_range(0, 99);
        it   = mk_item(cbm_pkg::OP_CPU_FETCH, 16'($urandom), 8'($urandom), 8'($urandom));
        if (pick < 30) begin
            // keep IRQ restart/ack rare so the counter gets to run
            grp = 3'($urandom_range(0, 7));
            if ((grp == cbm_pkg::GRP_IRQ_RESTART || grp == cbm_pkg::GRP_IRQ_ACK) &&
                $urandom_range(0, 3) != 0)
                grp = cbm_pkg::GRP_CHR_LO;
            if ($urandom_range(0, 9) == 0) it.op = cbm_pkg::OP_REG_WR;
            else it = group_write(grp);
        end else if (pick < 60) begin
            it.op = cbm_pkg::OP_TICK;
            if ($urandom_range(0, 7) == 0) it.cycles = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else if (pick < 80) begin
            it.op = cbm_pkg::OP_CPU_FETCH;
        end else begin
            it.op = cbm_pkg::OP_PPU_FETCH;
        end
        return it;
    endfunction

    // Random items with occasional IRQ sequences; gaps come and go in stretches
    task automatic run_random(int count, bit pressure);
        cbm_pkg::t_in_item it;
        int                sent;
        int                ticks;
        sent = 0;
        if (pressure) hold_req = 1'b1;
        while (sent < count) begin
            if (pressure && sent < 40) gaps_on = 1'b0;
            else gaps_on = ((sent / 40) % 2) == 0;
            if ($urandom_range(0, 19) == 0) begin
                send_item(group_write(cbm_pkg::GRP_IRQ_RESTART));
                ticks = $urandom_range(6, 24);
                for (int i = 0; i < ticks; i++) begin
                    it        = mk_item(cbm_pkg::OP_TICK, 16'($urandom), 8'($urandom),
                                        8'($urandom));
                    it.cycles = 8'($urandom_range(128, 255));
                    send_item(it);
                end
                send_item(rand_item());
                send_item(group_write(cbm_pkg::GRP_IRQ_ACK));
                sent += ticks + 3;
            end else begin
                send_item(rand_item());
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        cbm_pkg::t_in_item batch [$];
        rst_n        <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.item   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Variant 0: bank writes, ignored writes, fetch edges, IRQ on bit 10
        cfg_write(cbm_pkg::VARIANT_REG5);
        batch = {
            mk_item(cbm_pkg::OP_REG_WR,    16'h8000, 8'hFF, 8'h00),
            mk_item(cbm_pkg::OP_REG_WR,    16'h8002, 8'hA5, 8'h00),
            mk_item(cbm_pkg::OP_REG_WR,    16'h8003, 8'h55, 8'h00),
            mk_item(cbm_pkg::OP_REG_WR,    16'h7F81, 8'h12, 8'h00),
            mk_item(cbm_pkg::OP_REG_WR,    16'h8011, 8'h80, 8'h00),
            mk_item(cbm_pkg::OP_REG_WR,    16'hFFA3, 8'hFF, 8'h00),
            mk_item(cbm_pkg::OP_REG_WR,    16'h8052, 8'h01, 8'h00),
            mk_item(cbm_pkg::OP_REG_WR,    16'h8060, 8'hFF, 8'h00),
            mk_item(cbm_pkg::OP_REG_WR,    16'h8072, 8'hFF, 8'h00),
            mk_item(cbm_pkg::OP_CPU_FETCH, 16'h7FFF, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_CPU_FETCH, 16'h8000, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_CPU_FETCH, 16'hDFFF, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_CPU_FETCH, 16'hFFFF, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_PPU_FETCH, 16'h0000, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_PPU_FETCH, 16'h1FFF, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_PPU_FETCH, 16'h2800, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_PPU_FETCH, 16'h3EFF, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_PPU_FETCH, 16'h3F00, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_PPU_FETCH, 16'hFFFF, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_PPU_FETCH, 16'h4400, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_REG_WR,    16'h8030, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_TICK,      16'h0000, 8'h00, 8'hFF),
            mk_item(cbm_pkg::OP_TICK,      16'h0000, 8'h00, 8'hFF),
            mk_item(cbm_pkg::OP_TICK,      16'h0000, 8'h00, 8'hFF),
            mk_item(cbm_pkg::OP_TICK,      16'h0000, 8'h00, 8'hFF),
            mk_item(cbm_pkg::OP_TICK,      16'h0000, 8'h00, 8'hFF),
            mk_item(cbm_pkg::OP_REG_WR,    16'h8040, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_TICK,      16'h0000, 8'h00, 8'h00)
        };
        send_batch(batch);
        run_random(110, 1'b0);
        wait_idle();

        // Variant 1: nametable from CHR bit 7, group 5 ignored
        cfg_write(cbm_pkg::VARIANT_CHR7);
        batch = {
            mk_item(cbm_pkg::OP_REG_WR,    16'h8011, 8'h80, 8'h00),
            mk_item(cbm_pkg::OP_REG_WR,    16'h8051, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_PPU_FETCH, 16'h2400, 8'h00, 8'h00),
            mk_item(cbm_pkg::OP_PPU_FETCH, 16'h0400, 8'h00, 8'h00)
        };
        send_batch(batch);
        run_random(110, 1'b0);
        wait_idle();

        cfg_write(cbm_pkg::VARIANT_REG5);
        run_random(60, 1'b0);
        wait_idle();

        // Back up the input while the receiver holds off
        cfg_write(cbm_pkg::VARIANT_CHR7);
        run_random(100, 1'b1);
        wait_idle();
        repeat (10) @(posedge clk);

        $display("Covered %0d register writes, %0d ticks, %0d CPU and %0d PPU fetches",
                 board.op_seen[cbm_pkg::OP_REG_WR], board.op_seen[cbm_pkg::OP_TICK],
                 board.op_seen[cbm_pkg::OP_CPU_FETCH], board.op_seen[cbm_pkg::OP_PPU_FETCH]);
        $display("%0d words checked, %0d with IRQ high, %0d variant writes, %0d errors",
                 board.words_checked, board.irq_words, board.cfg_writes, board.errors);
        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
